/* design/first_fit_free_list_allocator_macros.svh */
// Assertion macros for the allocator checker.
`ifndef FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_FREE_LIST_ALLOCATOR_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define FFA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define FFA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ffa_pkg.sv */
package ffa_pkg;

  localparam int unsigned MaxRegions = 4096;
  localparam int unsigned IdxW = $clog2(MaxRegions);
  localparam int unsigned CntW = $clog2(MaxRegions + 1);

  localparam logic [31:0] RoundAdd  = 32'h0000_0fff;
  localparam logic [31:0] RoundMask = 32'hffff_f000;

  localparam logic [1:0] ModeAlloc      = 2'd0;
  localparam logic [1:0] ModeRelease    = 2'd1;
  localparam logic [1:0] ModeAlloc4k    = 2'd2;
  localparam logic [1:0] ModeRelease4k  = 2'd3;

  localparam logic [1:0] OutcomeOk      = 2'd0;
  localparam logic [1:0] OutcomeNoFit   = 2'd1;
  localparam logic [1:0] OutcomeLost    = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] req_size;
    logic [31:0] req_addr;
  } req_t;

  typedef struct packed {
    logic [31:0] alloc_addr;
    logic [1:0]  outcome;
    logic [31:0] free_total;
    logic [12:0] region_count;
    logic [12:0] peak_regions;
    logic [31:0] lost_count;
    logic [31:0] lost_bytes;
  } rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_WT,
    ST_SCAN_CHK,
    ST_DROP_RD,
    ST_DROP_WT,
    ST_DROP_WR,
    ST_INS_RD,
    ST_INS_WT,
    ST_INS_WR,
    ST_PREV_WT,
    ST_DECIDE,
    ST_RESP
  } state_t;

endpackage

/* design/ffa_ram.sv */
module ffa_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/first_fit_free_list_allocator.sv */
// First-fit free-list allocator.
//
// Channels: req (req_valid/req_ready, word req_t: mode, req_size, req_addr)
// and rsp (rsp_valid/rsp_ready, word rsp_t). One rsp word per req word.
// The free table lives in one RAM of 4096 (base, length) entries, sorted by
// base. A small sequencer walks it through the RAM's single read port, one
// entry at a time while searching (read, wait and check steps), and shifts
// entries one at a time (read, wait and write steps) when a region is dropped
// or a new one is inserted. The block takes one word at a time: req_ready is
// high only when idle, so a new word is not taken before the rsp word of the
// last one has been taken.
// The rsp word is held stable until taken; a stalled receiver only
// delays the next acceptance, nothing is lost.
// Reset (rst, synchronous) clears counters and the region count. The table
// itself is not cleared: only entries below the region count are read.
module first_fit_free_list_allocator (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ffa_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output ffa_pkg::rsp_t rsp
);
  import ffa_pkg::*;

  state_t state, state_next;

  // Request context
  logic          is_rel;
  logic [31:0]   size;
  logic [31:0]   addr;

  // Counters
  logic [CntW-1:0] count;
  logic [CntW-1:0] peak;
  logic [31:0]     lost_cnt;
  logic [31:0]     lost_byt;
  logic [31:0]     free_tot;

  // Result fields decided per word
  logic [31:0]     rsp_addr;
  logic [1:0]      rsp_outcome;

  // Walk pointer (CntW wide so it can hold count)
  logic [CntW-1:0] idx;
  // Previous entry kept while scanning for release
  logic [31:0]     prev_base;
  logic [31:0]     prev_len;
  // Current entry
  logic [31:0]     cur_base;
  logic [31:0]     cur_len;
  // Carried entry for insert ripple
  logic [63:0]     carry;
  logic [CntW-1:0] stop;

  // RAM port
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [63:0]     ram_wdata;
  logic [IdxW-1:0] ram_raddr;
  logic [63:0]     ram_rdata;

  logic [31:0]     rnd_size;
  logic [31:0]     cur_end;
  logic [31:0]     prev_end;
  logic [31:0]     rel_end;

  ffa_ram #(.Width(64), .Depth(MaxRegions)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rnd_size = (req.req_size + RoundAdd) & RoundMask;
  assign prev_end = prev_base + prev_len;
  assign rel_end  = addr + size;
  assign cur_end  = cur_base + cur_len;

  assign req_ready = (state == ST_IDLE);
  assign rsp_valid = (state == ST_RESP);

  // Next state / RAM control
  logic have_prev;
  logic have_cur;
  logic merge_prev;
  logic merge_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      peak     <= '0;
      lost_cnt <= '0;
      lost_byt <= '0;
      free_tot <= '0;
      idx      <= '0;
      have_prev <= 1'b0;
      have_cur  <= 1'b0;
      rsp_addr    <= '0;
      rsp_outcome <= OutcomeOk;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            is_rel    <= req.mode[0];
            size      <= req.mode[1] ? rnd_size : req.req_size;
            addr      <= req.req_addr;
            idx       <= '0;
            have_prev <= 1'b0;
            have_cur  <= 1'b0;
            rsp_addr    <= '0;
            rsp_outcome <= OutcomeOk;
          end
        end
        ST_SCAN_CHK: begin
          // ram_rdata holds entry idx
          cur_base <= ram_rdata[63:32];
          cur_len  <= ram_rdata[31:0];
          if (!is_rel) begin
            if (ram_rdata[31:0] < size) begin
              idx <= idx + 1'b1;
            end
          end else if (ram_rdata[63:32] > addr) begin
            have_cur <= 1'b1;
          end else begin
            prev_base <= ram_rdata[63:32];
            prev_len  <= ram_rdata[31:0];
            have_prev <= 1'b1;
            idx       <= idx + 1'b1;
          end
        end
        ST_DECIDE: begin
          if (!is_rel) begin
            if (!have_cur) begin
              rsp_outcome <= OutcomeNoFit;
            end else begin
              rsp_addr <= cur_base;
              free_tot <= free_tot - size;
              if (cur_len == size) begin
                count <= count - 1'b1;
              end
            end
          end else if (merge_prev) begin
            free_tot <= free_tot + size;
            if (merge_next) begin
              count <= count - 1'b1;
            end
          end else if (merge_next) begin
            free_tot <= free_tot + size;
          end else if (count != CntW'(MaxRegions)) begin
            free_tot <= free_tot + size;
            count    <= count + 1'b1;
            if (peak < count + 1'b1) begin
              peak <= count + 1'b1;
            end
            carry <= {addr, size};
            stop  <= count;
          end else begin
            rsp_outcome <= OutcomeLost;
            lost_cnt <= lost_cnt + 1'b1;
            lost_byt <= lost_byt + size;
          end
          // After a drop, the walk restarts at the entry after the removed one
          idx <= (is_rel && merge_prev && merge_next) ? idx + 1'b1
               : (!is_rel) ? idx + 1'b1 : idx;
        end
        ST_DROP_WR: begin
          idx <= idx + 1'b1;
        end
        ST_INS_WR: begin
          carry <= ram_rdata;
          idx   <= idx + 1'b1;
        end
        default: ;
      endcase
      // Alloc scan hit
      if (state == ST_SCAN_CHK && !is_rel && ram_rdata[31:0] >= size) begin
        have_cur <= 1'b1;
      end
    end
  end

  assign merge_prev = have_prev && (prev_end == addr);
  assign merge_next = have_cur && (rel_end == cur_base);

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx[IdxW-1:0];
    ram_wdata  = '0;
    ram_raddr  = idx[IdxW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (idx == count || (!is_rel && have_cur)) begin
          state_next = ST_DECIDE;
        end else begin
          state_next = ST_SCAN_WT;
        end
      end
      ST_SCAN_WT: state_next = ST_SCAN_CHK;
      ST_SCAN_CHK: begin
        if (is_rel && ram_rdata[63:32] > addr) begin
          state_next = ST_DECIDE;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_DECIDE: begin
        state_next = ST_RESP;
        if (!is_rel) begin
          if (have_cur) begin
            ram_we    = 1'b1;
            ram_wdata = {cur_base + size, cur_len - size};
            if (cur_len == size) begin
              state_next = ST_DROP_RD;
            end
          end
        end else if (merge_prev) begin
          ram_we    = 1'b1;
          ram_waddr = IdxW'(idx - 1'b1);
          ram_wdata = {prev_base, merge_next ? prev_len + size + cur_len
                                             : prev_len + size};
          if (merge_next) begin
            state_next = ST_DROP_RD;
          end
        end else if (merge_next) begin
          ram_we    = 1'b1;
          ram_wdata = {addr, cur_len + size};
        end else if (count != CntW'(MaxRegions)) begin
          state_next = ST_INS_RD;
        end
      end
      // Drop: entry idx-1 is gone; copy idx -> idx-1 while idx <= count
      ST_DROP_RD: begin
        if (idx > count) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_DROP_WT;
        end
      end
      ST_DROP_WT: state_next = ST_DROP_WR;
      ST_DROP_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = IdxW'(idx - 1'b1);
        ram_wdata  = ram_rdata;
        state_next = ST_DROP_RD;
      end
      // Insert: ripple carry from idx up to stop
      ST_INS_RD: begin
        if (idx == stop) begin
          ram_we     = 1'b1;
          ram_wdata  = carry;
          state_next = ST_RESP;
        end else begin
          state_next = ST_INS_WT;
        end
      end
      ST_INS_WT: state_next = ST_INS_WR;
      ST_INS_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = carry;
        state_next = ST_INS_RD;
      end
      ST_PREV_WT: state_next = ST_DECIDE;
      ST_RESP: begin
        if (rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output fields mirror the counters while the response is shown
  assign rsp.alloc_addr   = rsp_addr;
  assign rsp.outcome      = rsp_outcome;
  assign rsp.free_total   = free_tot;
  assign rsp.region_count = 13'(count);
  assign rsp.peak_regions = 13'(peak);
  assign rsp.lost_count   = lost_cnt;
  assign rsp.lost_bytes   = lost_byt;

endmodule

/* design/ffa_checker.sv */
module ffa_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input ffa_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input ffa_pkg::rsp_t rsp
);
  import ffa_pkg::*;
  `include "first_fit_free_list_allocator_macros.svh"

  `FFA_ASSERT_IMP(a_busy_excl, clk, rst, rsp_valid, !req_ready, "ready while result pending")
  `FFA_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "result changed while stalled")
  `FFA_ASSERT_IMP(a_lost_addr, clk, rst, rsp_valid && rsp.outcome == OutcomeLost, rsp.alloc_addr == 32'd0, "lost release with address")
  `FFA_ASSERT_IMP(a_peak, clk, rst, rsp_valid, rsp.region_count <= rsp.peak_regions, "count above peak")
endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (.*);

/* test/first_fit_free_list_allocator_tb.sv */
`timescale 1ns / 100ps

module first_fit_free_list_allocator_tb;
  import ffa_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  first_fit_free_list_allocator uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow of the free table: sorted by base, same wrap rules as the block.
  logic [31:0] free_base[$];
  logic [31:0] free_len[$];
  logic [31:0] free_sum = '0;
  logic [31:0] peak_seen = '0;
  logic [31:0] dropped_words = '0;
  logic [31:0] dropped_bytes = '0;

  rsp_t pending_rsp[$];
  int   mismatches = 0;
  int   words_sent = 0;
  int   words_checked = 0;
  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;

  // Next free-table state and response word for one request word.
  function automatic rsp_t apply_request(req_t w);
    rsp_t        r;
    logic [31:0] sz;
    logic [31:0] tail;
    int          i;
    bit          done;
    r    = '0;
    sz   = w.req_size;
    done = 1'b0;
    if (w.mode == ModeAlloc4k || w.mode == ModeRelease4k) sz = (sz + RoundAdd) & RoundMask;
    if (w.mode == ModeAlloc || w.mode == ModeAlloc4k) begin
      r.outcome = OutcomeNoFit;
      for (i = 0; i < free_base.size() && !done; i++) begin
        if (free_len[i] >= sz) begin
          r.alloc_addr = free_base[i];
          r.outcome    = OutcomeOk;
          free_base[i] = free_base[i] + sz;
          free_len[i]  = free_len[i] - sz;
          free_sum     = free_sum - sz;
          if (free_len[i] == 0) begin
            free_base.delete(i);
            free_len.delete(i);
          end
          done = 1'b1;
        end
      end
    end else begin
      tail = w.req_addr + sz;
      r.outcome = OutcomeOk;
      i = 0;
      while (i < free_base.size() && free_base[i] <= w.req_addr) i++;
      if (i > 0 && free_base[i-1] + free_len[i-1] == w.req_addr) begin
        // touches the region below; may also close the gap to the one above
        free_len[i-1] = free_len[i-1] + sz;
        free_sum = free_sum + sz;
        if (i < free_base.size() && tail == free_base[i]) begin
          free_len[i-1] = free_len[i-1] + free_len[i];
          free_base.delete(i);
          free_len.delete(i);
        end
      end else if (i < free_base.size() && tail == free_base[i]) begin
        free_base[i] = w.req_addr;
        free_len[i]  = free_len[i] + sz;
        free_sum     = free_sum + sz;
      end else if (free_base.size() < MaxRegions) begin
        free_base.insert(i, w.req_addr);
        free_len.insert(i, sz);
        free_sum = free_sum + sz;
        if (peak_seen < free_base.size()) peak_seen = free_base.size();
      end else begin
        r.outcome     = OutcomeLost;
        dropped_words = dropped_words + 1;
        dropped_bytes = dropped_bytes + sz;
      end
    end
    r.free_total   = free_sum;
    r.region_count = 13'(free_base.size());
    r.peak_regions = peak_seen[12:0];
    r.lost_count   = dropped_words;
    r.lost_bytes   = dropped_bytes;
    return r;
  endfunction

  // Receiver: random back-pressure per phase.
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Response checker against the oldest outstanding word.
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && rsp_ready) begin
      if (pending_rsp.size() == 0) begin
        $error("response word with nothing outstanding");
        mismatches++;
      end else begin
        e = pending_rsp.pop_front();
        check_field("alloc_addr", e.alloc_addr, rsp.alloc_addr);
        check_field("outcome", e.outcome, rsp.outcome);
        check_field("free_total", e.free_total, rsp.free_total);
        check_field("region_count", e.region_count, rsp.region_count);
        check_field("peak_regions", e.peak_regions, rsp.peak_regions);
        check_field("lost_count", e.lost_count, rsp.lost_count);
        check_field("lost_bytes", e.lost_bytes, rsp.lost_bytes);
        words_checked++;
      end
    end
  end

  // Sends one request word; called at a rising edge. When typed_in is set the
  // hand-written response is also compared with the shadow's prediction.
  task automatic send_request(req_t w, bit typed_in, rsp_t typed_rsp);
    rsp_t p;
    if ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    p = apply_request(w);
    if (typed_in && p !== typed_rsp) begin
      $error("row prediction: expected %h, got %h", typed_rsp, p);
      mismatches++;
    end
    pending_rsp.push_back(typed_in ? typed_rsp : p);
    words_sent++;
  endtask

  // Holds the request side quiet until every response word is back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  typedef struct {
    req_t w;
    bit   typed_in;
    rsp_t r;
  } stim_row_t;

  // Directed rows: empty table, zero-length regions, rounding wrap,
  // triple merge, address wrap, oversized requests.
  stim_row_t directed[] = '{
    '{'{ModeAlloc, 32'd100, 32'h0}, 1'b1,
      '{32'h0, OutcomeNoFit, 32'h0, 13'd0, 13'd0, 32'h0, 32'h0}},
    '{'{ModeRelease4k, 32'hffff_ffff, 32'h0}, 1'b1,
      '{32'h0, OutcomeOk, 32'h0, 13'd1, 13'd1, 32'h0, 32'h0}},
    '{'{ModeAlloc, 32'h0, 32'hffff_ffff}, 1'b1,
      '{32'h0, OutcomeOk, 32'h0, 13'd0, 13'd1, 32'h0, 32'h0}},
    '{'{ModeRelease, 32'h1000, 32'h1000}, 1'b0, '0},
    '{'{ModeRelease, 32'h1000, 32'h3000}, 1'b0, '0},
    '{'{ModeRelease, 32'h1000, 32'h2000}, 1'b0, '0},
    '{'{ModeRelease, 32'h1000, 32'hffff_f000}, 1'b0, '0},
    '{'{ModeRelease, 32'h10, 32'h0}, 1'b0, '0},
    '{'{ModeAlloc4k, 32'h1, 32'h0}, 1'b0, '0},
    '{'{ModeAlloc, 32'hffff_ffff, 32'h0}, 1'b0, '0},
    '{'{ModeRelease, 32'hffff_ffff, 32'h8000_0000}, 1'b0, '0},
    '{'{ModeAlloc, 32'h0, 32'h0}, 1'b0, '0},
    '{'{ModeRelease4k, 32'hffff_f001, 32'h5000}, 1'b0, '0},
    '{'{ModeRelease, 32'h0, 32'h4000}, 1'b0, '0},
    '{'{ModeAlloc4k, 32'hffff_ffff, 32'h0}, 1'b0, '0},
    '{'{ModeAlloc, 32'h10, 32'h0}, 1'b0, '0}
  };

  // Mostly releases on a 256-byte grid and allocations of up to 0x600 bytes, so that
  // merges and region drops happen often; about one word in five is fully random.
  function automatic req_t random_request();
    req_t w;
    w.mode = 2'($urandom_range(3));
    if ($urandom_range(99) < 20) begin
      w.req_size = $urandom;
      w.req_addr = $urandom;
    end else begin
      if (free_base.size() > 24) w.mode[0] = 1'b0;
      w.req_addr = $urandom_range(127) << 8;
      if (w.mode[0]) w.req_size = $urandom_range(1, 4) << 8;
      else w.req_size = $urandom_range(0, 32'h600);
    end
    return w;
  endfunction

  initial begin
    int phase;
    rsp_t none;
    none = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[k]) send_request(directed[k].w, directed[k].typed_in, directed[k].r);
    wait_drained();
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
        default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
      endcase
      repeat (25) begin
        if ($urandom_range(99) < 5) wait_drained();
        send_request(random_request(), 1'b0, none);
      end
    end
    wait_drained();
    repeat (200) @(posedge clk);
    $display("Sent %0d request words, checked %0d responses; peak %0d regions, %0d left.",
             words_sent, words_checked, peak_seen, free_base.size());
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
